// ----- hw/rtl/pict_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pict_pkg
// Shared types and codes for the prioritized interrupt and compare timer.
// ----------------------------------------------------------------------------
package pict_pkg;

   localparam int CMP_SLOTS   = 3;   // comparator storage slots
   localparam int LEVEL_SLOTS = 6;   // priority level mask registers
   localparam int WORD_W      = 32;

   // item kinds
   localparam logic [1:0] FUNC_LINE    = 2'd0;
   localparam logic [1:0] FUNC_ADVANCE = 2'd1;
   localparam logic [1:0] FUNC_COMPARE = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_LEVEL_TRIGGERED = 3'd0;
   localparam logic [2:0] CSR_LEVEL1_MASK     = 3'd1;
   localparam logic [2:0] CSR_LEVEL2_MASK     = 3'd2;
   localparam logic [2:0] CSR_LEVEL3_MASK     = 3'd3;
   localparam logic [2:0] CSR_LEVEL4_MASK     = 3'd4;
   localparam logic [2:0] CSR_LEVEL5_MASK     = 3'd5;
   localparam logic [2:0] CSR_LEVEL6_MASK     = 3'd6;
   localparam logic [2:0] CSR_TIMER_IRQ_MAP   = 3'd7;

   typedef struct packed {
      logic [1:0]        func;
      logic [5:0]        irq_index;
      logic              active;
      logic [WORD_W-1:0] delta;
      logic [1:0]        compare_index;
      logic [WORD_W-1:0] compare_value;
      logic [WORD_W-1:0] int_enable;
      logic [3:0]        current_level;
   } pict_item_type;

   typedef struct packed {
      logic [WORD_W-1:0]                pending;
      logic [WORD_W-1:0]                counter;
      logic [CMP_SLOTS-1:0][WORD_W-1:0] cmp;
   } pict_state_type;

endpackage

// ----- hw/rtl/pict_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pict_exec
// Applies one beat to the pending set, cycle counter and comparators.
// ----------------------------------------------------------------------------
module pict_exec
   import pict_pkg::*;
#(
   parameter int NUM_INTERRUPTS = 32,
   parameter int NUM_COMPARE    = 3
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  pict_item_type  item,
   input  logic [31:0]    level_triggered,
   input  logic [14:0]    timer_map,
   output pict_state_type state,
   output logic           bad
);

   localparam logic [5:0] NumIrq = 6'(NUM_INTERRUPTS);

   logic [WORD_W-1:0]                pending_ff, pending_in;
   logic [WORD_W-1:0]                counter_ff, counter_in;
   logic [CMP_SLOTS-1:0][WORD_W-1:0] cmp_ff, cmp_in;
   logic [CMP_SLOTS-1:0]             passed;

   assign bad = (item.func == FUNC_LINE) && (item.irq_index >= NumIrq);

   // comparator passed: distance from old count within delta
   always_comb begin
      for (int i = 0; i < CMP_SLOTS; i++) begin
         passed[i] = (i < NUM_COMPARE) && ((cmp_ff[i] - counter_ff) <= item.delta);
      end
   end

   always_comb begin
      logic [4:0] line;
      pending_in = pending_ff;
      counter_in = counter_ff;
      cmp_in     = cmp_ff;
      line       = '0;
      if (go) begin
         case (item.func)
            FUNC_LINE: begin
               if (!bad) begin
                  if (item.active) begin
                     pending_in[item.irq_index[4:0]] = 1'b1;
                  end else if (level_triggered[item.irq_index[4:0]]) begin
                     pending_in[item.irq_index[4:0]] = 1'b0;
                  end
               end
            end
            FUNC_ADVANCE: begin
               counter_in = counter_ff + item.delta;
               for (int i = 0; i < CMP_SLOTS; i++) begin
                  line = timer_map[5*i +: 5];
                  if (passed[i] && ({1'b0, line} < NumIrq)) begin
                     pending_in[line] = 1'b1;
                  end
               end
            end
            FUNC_COMPARE: begin
               for (int i = 0; i < CMP_SLOTS; i++) begin
                  if ((i < NUM_COMPARE) && (item.compare_index == 2'(i))) begin
                     cmp_in[i] = item.compare_value;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         counter_ff <= '0;
         cmp_ff     <= '0;
      end else begin
         pending_ff <= pending_in;
         counter_ff <= counter_in;
         cmp_ff     <= cmp_in;
      end
   end

   assign state.pending = pending_ff;
   assign state.counter = counter_ff;
   assign state.cmp     = cmp_ff;

   // state moves only on an executed beat
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(pending_ff) && $stable(counter_ff) && $stable(cmp_ff))
      else $error("state changed without an executed beat");

   // counter only moves on an advance
   a_counter_advance: assert property (@(posedge clock) disable iff (reset)
      go && (item.func != FUNC_ADVANCE) |=> $stable(counter_ff))
      else $error("counter moved on a non-advance beat");

   // a bad line index leaves the pending set alone
   a_bad_ignored: assert property (@(posedge clock) disable iff (reset)
      go && bad |=> $stable(pending_ff))
      else $error("bad line index changed pending set");

endmodule

// ----- hw/rtl/pict_resolve.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pict_resolve
// Picks the highest enabled pending level and the nearest comparator wake.
// ----------------------------------------------------------------------------
module pict_resolve
   import pict_pkg::*;
#(
   parameter int NUM_LEVELS  = 6,
   parameter int NUM_COMPARE = 3
) (
   input  pict_state_type                     state,
   input  logic [LEVEL_SLOTS-1:0][WORD_W-1:0] prio_mask,
   input  logic [WORD_W-1:0]                  int_enable,
   input  logic [3:0]                         current_level,
   output logic [2:0]                         pending_level,
   output logic [WORD_W-1:0]                  next_wake
);

   logic [WORD_W-1:0]                live;
   logic [LEVEL_SLOTS-1:0]           hit;
   logic [CMP_SLOTS-1:0][WORD_W-1:0] cmp_gap;

   assign live = state.pending & int_enable;

   always_comb begin
      for (int lv = 1; lv <= LEVEL_SLOTS; lv++) begin
         hit[lv-1] = (lv <= NUM_LEVELS) && (4'(lv) > current_level)
                     && (|(prio_mask[lv-1] & live));
      end
   end

   // highest hit wins
   always_comb begin
      pending_level = '0;
      for (int lv = 1; lv <= LEVEL_SLOTS; lv++) begin
         if (hit[lv-1]) pending_level = 3'(lv);
      end
   end

   always_comb begin
      for (int i = 0; i < CMP_SLOTS; i++) begin
         cmp_gap[i] = state.cmp[i] - state.counter;
      end
   end

   // strict less-than keeps the lower comparator on a tie
   always_comb begin
      logic [WORD_W-1:0] best_dist;
      next_wake = state.counter - 1'b1;
      best_dist = '1;
      for (int i = 0; i < CMP_SLOTS; i++) begin
         if ((i < NUM_COMPARE) && (cmp_gap[i] < best_dist)) begin
            next_wake = state.cmp[i];
            best_dist = cmp_gap[i];
         end
      end
   end

endmodule

// ----- hw/rtl/prioritized_interrupt_and_compare_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prioritized_interrupt_and_compare_timer_top
// Interrupt controller with pending set, priority levels, cycle counter and
// compare timers.
// ----------------------------------------------------------------------------
//
//  Port group  Dir   Handshake            Carries
//  req_*       in    req_valid/req_ready  one beat: line change, advance,
//                                         or comparator write
//  rsp_*       out   rsp_valid/rsp_ready  one result beat per request beat
//  csr_*       in    csr_we               register write, no read-back
//
//  One beat per clock sustained while rsp_ready stays high. A beat passes
//  the input register, the state update and the result register in order.
//  Throughput is set by the state update (counter add plus
//  comparator pass checks feeding the pending set).
//  Reset clears the pending set, counter, comparators, csr registers and valid flags.
//  A stalled rsp_ready backs up through the stages to req_ready; the
//  result register holds while the next beats wait behind it.
// ----------------------------------------------------------------------------
module prioritized_interrupt_and_compare_timer_top
   import pict_pkg::*;
#(
   parameter int NUM_INTERRUPTS = 32,
   parameter int NUM_LEVELS     = 6,
   parameter int NUM_COMPARE    = 3
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_irq_index,
   input  logic        req_active,
   input  logic [31:0] req_delta,
   input  logic [1:0]  req_compare_index,
   input  logic [31:0] req_compare_value,
   input  logic [31:0] req_int_enable,
   input  logic [3:0]  req_current_level,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_pending_level,
   output logic        rsp_irq_request,
   output logic [31:0] rsp_pending_bits,
   output logic [31:0] rsp_cycle_count,
   output logic [31:0] rsp_next_wake,
   output logic        rsp_bad_irq,
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [WORD_W-1:0] LineMask = (NUM_INTERRUPTS >= WORD_W) ? '1 :
      WORD_W'((64'd1 << NUM_INTERRUPTS) - 64'd1);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [WORD_W-1:0]                  level_trig_ff, level_trig_in;
   logic [LEVEL_SLOTS-1:0][WORD_W-1:0] prio_mask_ff, prio_mask_in;
   logic [14:0]                        timer_map_ff, timer_map_in;
   logic [2:0]                         mask_sel;

   always_comb begin
      level_trig_in = level_trig_ff;
      prio_mask_in  = prio_mask_ff;
      timer_map_in  = timer_map_ff;
      mask_sel      = 3'(csr_index - CSR_LEVEL1_MASK);
      if (csr_we) begin
         unique case (csr_index) inside
            CSR_LEVEL_TRIGGERED: level_trig_in = csr_wdata;
            CSR_LEVEL1_MASK, CSR_LEVEL2_MASK, CSR_LEVEL3_MASK,
            CSR_LEVEL4_MASK, CSR_LEVEL5_MASK, CSR_LEVEL6_MASK:
               prio_mask_in[mask_sel] = csr_wdata;
            CSR_TIMER_IRQ_MAP:   timer_map_in = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_trig_ff <= '0;
         prio_mask_ff  <= '0;
         timer_map_ff  <= '0;
      end else begin
         level_trig_ff <= level_trig_in;
         prio_mask_ff  <= prio_mask_in;
         timer_map_ff  <= timer_map_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------
   logic in_valid_ff, in_valid_in;
   logic mid_valid_ff, mid_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire, exec_go, mid_go;

   assign mid_go    = mid_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign exec_go   = in_valid_ff && (!mid_valid_ff || mid_go);
   assign req_ready = !in_valid_ff || exec_go;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (exec_go ? 1'b0 : in_valid_ff);
      mid_valid_in = exec_go ? 1'b1 : (mid_go ? 1'b0 : mid_valid_ff);
      rsp_valid_in = mid_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   pict_item_type item_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.func          <= req_func;
         item_ff.irq_index     <= req_irq_index;
         item_ff.active        <= req_active;
         item_ff.delta         <= req_delta;
         item_ff.compare_index <= req_compare_index;
         item_ff.compare_value <= req_compare_value;
         item_ff.int_enable    <= req_int_enable;
         item_ff.current_level <= req_current_level;
      end
   end

   // ------------------------------------------------------------------
   // State update
   // ------------------------------------------------------------------
   pict_state_type state;
   logic           exec_bad;

   pict_exec #(
      .NUM_INTERRUPTS (NUM_INTERRUPTS),
      .NUM_COMPARE    (NUM_COMPARE)
   ) u_exec (
      .clock           (clock),
      .reset           (reset),
      .go              (exec_go),
      .item            (item_ff),
      .level_triggered (level_trig_ff),
      .timer_map       (timer_map_ff),
      .state           (state),
      .bad             (exec_bad)
   );

   // beat fields that ride along to the resolve stage; state registers
   // hold this beat's result while it sits here
   logic [WORD_W-1:0] mid_enable_ff;
   logic [3:0]        mid_level_ff;
   logic              mid_bad_ff;

   always_ff @(posedge clock) begin
      if (exec_go) begin
         mid_enable_ff <= item_ff.int_enable;
         mid_level_ff  <= item_ff.current_level;
         mid_bad_ff    <= exec_bad;
      end
   end

   // ------------------------------------------------------------------
   // Level and wake resolve, result register
   // ------------------------------------------------------------------
   logic [2:0]        res_level;
   logic [WORD_W-1:0] res_wake;

   pict_resolve #(
      .NUM_LEVELS  (NUM_LEVELS),
      .NUM_COMPARE (NUM_COMPARE)
   ) u_resolve (
      .state         (state),
      .prio_mask     (prio_mask_ff),
      .int_enable    (mid_enable_ff),
      .current_level (mid_level_ff),
      .pending_level (res_level),
      .next_wake     (res_wake)
   );

   logic [2:0]        rsp_level_ff;
   logic [WORD_W-1:0] rsp_pending_ff;
   logic [WORD_W-1:0] rsp_count_ff;
   logic [WORD_W-1:0] rsp_wake_ff;
   logic              rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (mid_go) begin
         rsp_level_ff   <= res_level;
         rsp_pending_ff <= state.pending;
         rsp_count_ff   <= state.counter;
         rsp_wake_ff    <= res_wake;
         rsp_bad_ff     <= mid_bad_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pending_level = rsp_level_ff;
   assign rsp_irq_request   = (rsp_level_ff != 3'd0);
   assign rsp_pending_bits  = rsp_pending_ff;
   assign rsp_cycle_count   = rsp_count_ff;
   assign rsp_next_wake     = rsp_wake_ff;
   assign rsp_bad_irq       = rsp_bad_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_lines_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_pending_ff & ~LineMask) == '0))
      else $error("pending bit set beyond line count");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_level_ff) <= 32'(NUM_LEVELS)))
      else $error("pending level beyond level count");

   // a held middle beat keeps its slot and the state it resolves from
   a_mid_held: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && !mid_go |=> mid_valid_ff && $stable(state))
      else $error("middle beat lost or state moved under it");

   a_bad_only_line: assert property (@(posedge clock) disable iff (reset)
      mid_go && mid_bad_ff |=> rsp_bad_ff && (rsp_count_ff == $past(state.counter)))
      else $error("bad line flag lost or counter mismatch");

endmodule

// ----- tb/tb_prioritized_interrupt_and_compare_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prioritized_interrupt_and_compare_timer_top
// Self-checking bench for the interrupt controller with compare timers. A
// short directed table comes first. Random phases follow, each with its own
// register setup. Every result beat is checked field by field against a
// typed status or a local copy of the pending set, cycle counter and comparators.
// ----------------------------------------------------------------------------
module tb_prioritized_interrupt_and_compare_timer_top;
   import pict_pkg::*;

   localparam int N_LINES         = 32;
   localparam int N_LEVELS        = 6;
   localparam int N_CMP           = 3;
   localparam int PHASES          = 14;
   localparam int PHASE_BEATS     = 125;
   localparam int HOLD_OFF_CYCLES = 80;    // long sink stall, fills the pipe
   localparam int IDLE_LIMIT      = 2000;  // cycles with no beat on either side

   // the package leaves the fourth item kind unnamed; the block must ignore it
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0]  pending_level;
      logic        irq_request;
      logic [31:0] pending_bits;
      logic [31:0] cycle_count;
      logic [31:0] next_wake;
      logic        bad_irq;
   } irq_status_type;

   // one row of the directed table: either a register write or a beat
   typedef struct {
      bit             is_csr;
      logic [2:0]     csr_idx;
      logic [31:0]    csr_val;
      pict_item_type  beat;
      bit             typed;  // status typed in by hand, not predicted
      irq_status_type want;
   } plan_row_type;

   // ------------------------------------------------------------------------
   // clock, reset and DUT inputs; every input is known from time zero
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_LINE;
   logic [5:0]  req_irq_index = '0;
   logic        req_active = 1'b0;
   logic [31:0] req_delta = '0;
   logic [1:0]  req_compare_index = '0;
   logic [31:0] req_compare_value = '0;
   logic [31:0] req_int_enable = '0;
   logic [3:0]  req_current_level = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_pending_level;
   logic        rsp_irq_request;
   logic [31:0] rsp_pending_bits;
   logic [31:0] rsp_cycle_count;
   logic [31:0] rsp_next_wake;
   logic        rsp_bad_irq;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_LEVEL_TRIGGERED;
   logic [31:0] csr_wdata = '0;

   always #5 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   prioritized_interrupt_and_compare_timer_top #(
      .NUM_INTERRUPTS (N_LINES),
      .NUM_LEVELS     (N_LEVELS),
      .NUM_COMPARE    (N_CMP)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_irq_index     (req_irq_index),
      .req_active        (req_active),
      .req_delta         (req_delta),
      .req_compare_index (req_compare_index),
      .req_compare_value (req_compare_value),
      .req_int_enable    (req_int_enable),
      .req_current_level (req_current_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pending_level (rsp_pending_level),
      .rsp_irq_request   (rsp_irq_request),
      .rsp_pending_bits  (rsp_pending_bits),
      .rsp_cycle_count   (rsp_cycle_count),
      .rsp_next_wake     (rsp_next_wake),
      .rsp_bad_irq       (rsp_bad_irq),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // shadow state: registers as last written, plus the block's own state
   // ------------------------------------------------------------------------
   logic [31:0] trig_lines = '0;             // level-triggered lines
   logic [31:0] prio_mask [1:N_LEVELS] = '{default: '0};
   logic [14:0] timer_lines = '0;            // 5-bit line per comparator
   logic [31:0] pend_lines = '0;
   logic [31:0] tick_count = '0;
   logic [31:0] cmp_value [N_CMP] = '{default: '0};

   irq_status_type status_due_q[$];          // statuses owed by the block
   plan_row_type   plan[$];
   int             fail_count = 0;
   bit             steady = 1'b0;            // no idling on either side
   bit             hold_off_request = 1'b0;  // sink should stall for a while
   int             idle_cycles = 0;

   // Applies one beat to the shadow state and returns the status the block
   // must report for it.
   function automatic irq_status_type step_irq_timer(input pict_item_type b);
      irq_status_type r;
      logic [31:0] prior;
      logic [31:0] live;
      logic [31:0] span;
      logic [31:0] reach;
      logic [31:0] best;
      logic [4:0]  line;
      r = '0;
      case (b.func)
         FUNC_LINE: begin
            if (b.irq_index >= N_LINES)
               r.bad_irq = 1'b1;
            else if (b.active)
               pend_lines[b.irq_index] = 1'b1;
            else if (trig_lines[b.irq_index])
               pend_lines[b.irq_index] = 1'b0;  // edge lines keep their bit
         end
         FUNC_ADVANCE: begin
            prior = tick_count;
            tick_count = prior + b.delta;
            // a comparator is passed when it lies within [prior, prior+delta]
            // going forward mod 2^32, its own value included
            for (int k = 0; k < N_CMP; k++) begin
               span = cmp_value[k] - prior;
               if (span <= b.delta) begin
                  line = timer_lines[5*k +: 5];
                  if (line < N_LINES)
                     pend_lines[line] = 1'b1;
               end
            end
         end
         FUNC_COMPARE: begin
            if (b.compare_index < N_CMP)
               cmp_value[b.compare_index] = b.compare_value;
         end
         default: ;
      endcase

      // highest level above the current one with an enabled pending line
      live = pend_lines & b.int_enable;
      for (int lv = N_LEVELS; lv >= 1; lv--) begin
         if (r.pending_level == 0 && lv > b.current_level && (prio_mask[lv] & live) != 0)
            r.pending_level = 3'(lv);
      end

      // nearest comparator ahead; a full turn (counter - 1) when none is nearer
      best = tick_count - 1;
      for (int k = 0; k < N_CMP; k++) begin
         span  = cmp_value[k] - tick_count;
         reach = best - tick_count;
         if (span < reach)
            best = cmp_value[k];
      end

      r.irq_request  = (r.pending_level != 0);
      r.pending_bits = pend_lines;
      r.cycle_count  = tick_count;
      r.next_wake    = best;
      return r;
   endfunction

   function automatic int unsigned pick_wait();
      return steady ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         fail_count++;
      end
   endfunction

   // Random beat: every field gets noise, then the fields that matter for the
   // chosen kind are shaped so comparators sit close to the counter and
   // advances land on them, just short of them, or far beyond.
   function automatic pict_item_type random_beat();
      pict_item_type b;
      logic [127:0]  noise;
      int unsigned   pick;
      int unsigned   k;
      noise = {$urandom, $urandom, $urandom, $urandom};
      b = noise[$bits(pict_item_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         b.func = FUNC_LINE;
         b.irq_index = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(32, 63))
                                                   : 6'($urandom_range(0, 31));
      end else if (pick < 70) begin
         b.func = FUNC_ADVANCE;
         k = $urandom_range(0, N_CMP - 1);
         case ($urandom_range(0, 7))
            0:       b.delta = '0;
            1:       b.delta = $urandom;
            2, 3:    b.delta = cmp_value[k] - tick_count - $urandom_range(0, 1);
            default: b.delta = $urandom_range(0, 300);
         endcase
      end else if (pick < 95) begin
         b.func = FUNC_COMPARE;
         b.compare_index = ($urandom_range(0, 9) == 0) ? 2'd3
                                                       : 2'($urandom_range(0, N_CMP - 1));
         case ($urandom_range(0, 5))
            0:       b.compare_value = $urandom;
            1:       b.compare_value = tick_count - 1;
            default: b.compare_value = tick_count + $urandom_range(0, 600);
         endcase
      end else begin
         b.func = FUNC_UNUSED;
      end
      case ($urandom_range(0, 3))
         0:       b.int_enable = '1;
         1:       b.int_enable = $urandom & $urandom;
         default: b.int_enable = $urandom;
      endcase
      b.current_level = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, N_LEVELS));
      return b;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // Offers one beat after a random gap. Returns at the accepting edge with
   // valid still high, so a back-to-back beat never drops valid.
   task automatic send_beat(input pict_item_type b, input bit typed,
                            input irq_status_type want);
      int unsigned    gap;
      irq_status_type due;
      gap = pick_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= b.func;
      req_irq_index     <= b.irq_index;
      req_active        <= b.active;
      req_delta         <= b.delta;
      req_compare_index <= b.compare_index;
      req_compare_value <= b.compare_value;
      req_int_enable    <= b.int_enable;
      req_current_level <= b.current_level;
      do @(posedge clock); while (!req_ready);
      due = step_irq_timer(b);
      status_due_q.push_back(typed ? want : due);
   endtask

   // Stops offering and waits for the pipe to empty; the block always answers,
   // so an empty queue plus the tail wait means it is idle.
   task automatic settle(input int unsigned tail);
      req_valid <= 1'b0;
      while (status_due_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Lowers csr_we again after each write so it is never lowered and raised in one step.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LEVEL_TRIGGERED: trig_lines  = data;
         CSR_TIMER_IRQ_MAP:   timer_lines = data[14:0];
         default:             prio_mask[idx] = data;
      endcase
   endtask

   // First phase clears everything, second sets every bit (the map register
   // must drop the upper bits), the rest are random with mixed mask density.
   task automatic program_phase(input int phase);
      logic [31:0] v;
      for (int k = CSR_LEVEL_TRIGGERED; k <= CSR_TIMER_IRQ_MAP; k++) begin
         if (phase == 0)
            v = '0;
         else if (phase == 1)
            v = '1;
         else if (k == CSR_LEVEL_TRIGGERED || k == CSR_TIMER_IRQ_MAP)
            v = $urandom;
         else begin
            case ($urandom_range(0, 2))
               0:       v = $urandom;
               1:       v = $urandom & $urandom & $urandom;
               default: v = 32'd1 << $urandom_range(0, 31);
            endcase
         end
         write_csr(k[2:0], v);
      end
   endtask

   task automatic add_beat(input logic [1:0] func, input logic [5:0] irq, input logic act,
                           input logic [31:0] delta, input logic [1:0] cidx,
                           input logic [31:0] cval, input logic [31:0] en,
                           input logic [3:0] lvl);
      plan_row_type row;
      row = '{default: '0};
      row.beat = '{func, irq, act, delta, cidx, cval, en, lvl};
      plan.push_back(row);
   endtask

   task automatic add_csr(input logic [2:0] idx, input logic [31:0] val);
      plan_row_type row;
      row = '{default: '0};
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      plan.push_back(row);
   endtask

   // hand-typed status for the row just added
   task automatic add_check(input logic [2:0] lvl, input logic [31:0] pend,
                            input logic [31:0] cnt, input logic [31:0] wake,
                            input logic bad);
      plan[$].typed = 1'b1;
      plan[$].want  = '{lvl, lvl != 0, pend, cnt, wake, bad};
   endtask

   initial begin : stimulus
      bit flowing;
      flowing = 1'b0;
      do @(posedge clock); while (reset);

      // -- directed table --------------------------------------------------
      // After reset every register is zero, comparators sit at zero and so
      // does the counter, so the nearest wake point is zero itself.
      add_beat(FUNC_LINE, 6'd0, 1'b1, '0, 2'd0, '0, '1, 4'd0);
      add_check(3'd0, 32'h1, 32'h0, 32'h0, 1'b0);
      // line index past the last line: flagged, nothing changes
      add_beat(FUNC_LINE, 6'd63, 1'b1, '0, 2'd0, '0, '1, 4'd0);
      add_check(3'd0, 32'h1, 32'h0, 32'h0, 1'b1);
      add_beat(FUNC_LINE, 6'd32, 1'b1, '0, 2'd0, '0, '1, 4'd0);
      add_check(3'd0, 32'h1, 32'h0, 32'h0, 1'b1);
      // unused kind with loud payload: ignored
      add_beat(FUNC_UNUSED, 6'd5, 1'b1, '1, 2'd1, 32'd5, '1, 4'd0);
      add_check(3'd0, 32'h1, 32'h0, 32'h0, 1'b0);
      // largest advance, then one more to wrap; both pass comparator 0
      add_beat(FUNC_ADVANCE, 6'd0, 1'b0, '1, 2'd0, '0, '1, 4'd0);
      add_check(3'd0, 32'h1, 32'hFFFF_FFFF, 32'h0, 1'b0);
      add_beat(FUNC_ADVANCE, 6'd0, 1'b0, 32'd1, 2'd0, '0, '1, 4'd0);
      add_check(3'd0, 32'h1, 32'h0, 32'h0, 1'b0);

      add_csr(CSR_LEVEL_TRIGGERED, 32'h0000_FFFF);
      add_csr(CSR_LEVEL1_MASK, 32'h0000_00FF);
      add_csr(CSR_LEVEL2_MASK, 32'h0000_FF00);
      add_csr(CSR_LEVEL3_MASK, 32'h00FF_0000);
      add_csr(CSR_LEVEL4_MASK, 32'h0F00_0000);
      add_csr(CSR_LEVEL5_MASK, 32'h3000_0000);
      add_csr(CSR_LEVEL6_MASK, 32'hC000_0000);
      add_csr(CSR_TIMER_IRQ_MAP, {17'd0, 5'd31, 5'd9, 5'd4});

      // top line hits the top level; a current level of 15 hides it
      add_beat(FUNC_LINE, 6'd31, 1'b1, '0, 2'd0, '0, '1, 4'd0);
      add_beat(FUNC_LINE, 6'd31, 1'b0, '0, 2'd0, '0, '1, 4'd15);  // edge line keeps bit
      add_beat(FUNC_LINE, 6'd3, 1'b1, '0, 2'd0, '0, '1, 4'd5);
      add_beat(FUNC_LINE, 6'd3, 1'b0, '0, 2'd0, '0, '0, 4'd0);    // level line clears
      add_beat(FUNC_COMPARE, 6'd0, 1'b0, '0, 2'd0, 32'd100, '1, 4'd0);
      add_beat(FUNC_COMPARE, 6'd0, 1'b0, '0, 2'd1, 32'd50, '1, 4'd0);
      add_beat(FUNC_COMPARE, 6'd0, 1'b0, '0, 2'd2, '1, '1, 4'd0);
      add_beat(FUNC_COMPARE, 6'd0, 1'b0, '0, 2'd3, 32'd7, '1, 4'd0);  // no such slot
      add_beat(FUNC_ADVANCE, 6'd0, 1'b0, 32'd60, 2'd0, '0, '1, 4'd1);
      add_beat(FUNC_COMPARE, 6'd0, 1'b0, '0, 2'd0, 32'd60, '1, 4'd0);
      add_beat(FUNC_ADVANCE, 6'd0, 1'b0, 32'd0, 2'd0, '0, '1, 4'd0);  // lands exactly
      add_beat(FUNC_ADVANCE, 6'd0, 1'b0, '1, 2'd0, '0, '1, 4'd2);     // passes all three

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (flowing)
               settle(4);
            flowing = 1'b0;
            write_csr(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);
            flowing = 1'b1;
         end
      end

      // -- random phases ---------------------------------------------------
      for (int phase = 0; phase < PHASES; phase++) begin
         settle(4);
         steady = (phase % 5 == 2);
         program_phase(phase);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (phase == 3 && n == 40)
               hold_off_request = 1'b1;
            send_beat(random_beat(), 1'b0, '0);
         end
      end

      settle(8);
      if (fail_count == 0)
         $display("** prioritized_interrupt_and_compare_timer_top: PASSED **");
      else
         $display("** prioritized_interrupt_and_compare_timer_top: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: random stalls, one long hold-off on request, and a check
   // of each accepted beat against the oldest owed status
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned    stall;
      irq_status_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_wait();
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (status_due_q.size() == 0) begin
            $error("result beat with no status owed");
            fail_count++;
         end else begin
            want = status_due_q.pop_front();
            check_field("pending_level", want.pending_level, rsp_pending_level);
            check_field("irq_request", want.irq_request, rsp_irq_request);
            check_field("pending_bits", want.pending_bits, rsp_pending_bits);
            check_field("cycle_count", want.cycle_count, rsp_cycle_count);
            check_field("next_wake", want.next_wake, rsp_next_wake);
            check_field("bad_irq", want.bad_irq, rsp_bad_irq);
         end
      end
   end

   // watchdog: too long without a beat on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $error("no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("** prioritized_interrupt_and_compare_timer_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
